[sv/ptw_pkg.sv]
// Shared types and codes for the four-level page-table walker.
// No dependencies; used by ptw_step and four_level_page_table_walker.
`default_nettype none

package ptw_pkg;

  // Input word selector
  localparam logic ReqNew  = 1'b0;
  localparam logic ReqResp = 1'b1;

  // Result word kind
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // Walk level codes; codes above LvlFour are treated as idle
  localparam int unsigned LevelBits = 3;
  localparam logic [LevelBits-1:0] LvlIdle  = 3'd0;
  localparam logic [LevelBits-1:0] LvlOne   = 3'd1;
  localparam logic [LevelBits-1:0] LvlTwo   = 3'd2;
  localparam logic [LevelBits-1:0] LvlThree = 3'd3;
  localparam logic [LevelBits-1:0] LvlFour  = 3'd4;

  localparam logic [63:0] PresentBit  = 64'h1;
  localparam logic [63:0] LargePgBit  = 64'h80;

  typedef struct packed {
    logic        req_type;
    logic [35:0] dir_base;
    logic [47:0] virt_addr;
    logic [63:0] read_data;
  } ptw_in_t;

  typedef struct packed {
    logic        out_kind;
    logic [36:0] read_addr;
    logic [51:0] phys_addr;
    logic        fault;
  } ptw_out_t;

  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic [47:0]          linear;
  } ptw_state_t;

endpackage

`default_nettype wire

[sv/ptw_step.sv]
// Combinational step of the walker: one input word plus walk state in,
// next walk state and an optional result word out. Depends on ptw_pkg.
`default_nettype none

module ptw_step #(
  parameter int unsigned PHYS_BITS = 36
) (
  input  ptw_pkg::ptw_in_t    item_i,
  input  ptw_pkg::ptw_state_t state_i,
  output ptw_pkg::ptw_state_t state_o,
  output logic                res_valid_o,
  output ptw_pkg::ptw_out_t   res_o
);
  import ptw_pkg::*;

  localparam logic [63:0] PhysLimit = 64'((65'd1 << PHYS_BITS) - 65'd1);
  localparam logic [63:0] Frame4k   = PhysLimit & ~64'hFFF;
  localparam logic [63:0] Frame2m   = PhysLimit & ~64'h1F_FFFF;
  localparam logic [63:0] Frame1g   = PhysLimit & ~64'h3FFF_FFFF;

  logic [63:0] entry;
  logic [47:0] lin;
  logic        present;
  logic        large_pg;
  logic [63:0] frame_4k;

  // one adder for entry addresses, one for the final address
  logic [36:0] rd_base;
  logic [8:0]  rd_idx;
  logic [36:0] rd_sum;
  logic [51:0] pa_frame;
  logic [29:0] pa_off;
  logic [51:0] pa_sum;

  logic        is_read;
  logic        is_fault;

  assign entry    = item_i.read_data;
  assign lin      = state_i.linear;
  assign present  = |(entry & PresentBit);
  assign large_pg = |(entry & LargePgBit);
  assign frame_4k = entry & Frame4k;

  always_comb begin
    rd_base = frame_4k[36:0];
    rd_idx  = lin[38:30];
    if (item_i.req_type == ReqNew) begin
      rd_base = {1'b0, item_i.dir_base[35:4], 4'b0000};
      rd_idx  = item_i.virt_addr[47:39];
    end else begin
      case (state_i.level)
        LvlTwo:   rd_idx = lin[29:21];
        LvlThree: rd_idx = lin[20:12];
        default:  rd_idx = lin[38:30];
      endcase
    end
  end

  assign rd_sum = rd_base + {25'd0, rd_idx, 3'b000};

  always_comb begin
    case (state_i.level)
      LvlTwo: begin
        pa_frame = 52'(entry & Frame1g);
        pa_off   = lin[29:0];
      end
      LvlThree: begin
        pa_frame = 52'(entry & Frame2m);
        pa_off   = {9'd0, lin[20:0]};
      end
      default: begin
        pa_frame = frame_4k[51:0];
        pa_off   = {18'd0, lin[11:0]};
      end
    endcase
  end

  assign pa_sum = pa_frame + {22'd0, pa_off};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b1;
    is_read     = 1'b0;
    is_fault    = 1'b0;
    if (item_i.req_type == ReqNew) begin
      // a request abandons any walk in flight
      state_o.level  = LvlOne;
      state_o.linear = item_i.virt_addr;
      is_read        = 1'b1;
    end else begin
      case (state_i.level)
        LvlOne: begin
          if (!present) begin
            is_fault = 1'b1;
          end else begin
            is_read = 1'b1;
          end
        end
        LvlTwo, LvlThree: begin
          if (!present) begin
            is_fault = 1'b1;
          end else if (!large_pg) begin
            is_read = 1'b1;
          end
        end
        LvlFour: begin
          if (!present || frame_4k == 64'd0) begin
            is_fault = 1'b1;
          end
        end
        default: begin
          // response with no walk pending is dropped
          res_valid_o = 1'b0;
        end
      endcase
      if (is_read) begin
        state_o.level = state_i.level + LevelBits'(1);
      end else begin
        state_o.level = LvlIdle;
      end
    end
  end

  always_comb begin
    res_o.out_kind  = is_read ? KindRead : KindDone;
    res_o.read_addr = is_read ? rd_sum : 37'd0;
    res_o.phys_addr = (is_read || is_fault) ? 52'd0 : pa_sum;
    res_o.fault     = is_fault;
  end

endmodule

`default_nettype wire

[sv/four_level_page_table_walker.sv]
// Four-level page-table walker for 48-bit linear addresses: a request word
// starts a walk and returns the first entry address; each memory response word
// returns the next entry address or the finished translation (or a fault).
// Throughput is one word per cycle while the output is not stalled: a word is
// captured in the input register, the walk step (one 37-bit address add and
// one 52-bit translation add) is combinational, and the answer sits in the
// result register. Responses arriving with no walk pending give no result;
// a request during a walk restarts it. PHYS_BITS (32..52) sets the frame
// width taken from the entries.
// Depends on ptw_pkg and ptw_step.
`default_nettype none

module four_level_page_table_walker #(
  parameter int unsigned PHYS_BITS = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptw_pkg::ptw_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptw_pkg::ptw_out_t out_item_o
);
  import ptw_pkg::*;

  logic       in_valid_q;
  ptw_in_t    in_item_q;
  ptw_state_t state_q;
  ptw_state_t state_d;
  logic       out_valid_q;
  ptw_out_t   out_item_q;

  logic       res_valid;
  ptw_out_t   res;
  logic       out_free;
  logic       consume;
  logic       in_load;

  ptw_step #(
    .PHYS_BITS (PHYS_BITS)
  ) u_step (
    .item_i      (in_item_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // a word with no result never waits on the output side
  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (out_free || !res_valid);
  assign in_stall_o = in_valid_q && !consume;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      state_q.level  <= LvlIdle;
      state_q.linear <= 48'd0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        state_q <= state_d;
      end
      if (consume && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
    if (consume && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a captured word only waits behind a stalled result
  a_wait_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |-> out_valid_q && out_stall_i)
    else $error("input word held without a stalled result");

  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_item_q.req_type == ReqNew |=> state_q.level == LvlOne)
    else $error("request did not start a walk");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && res_valid && res.out_kind == KindDone |=> state_q.level == LvlIdle)
    else $error("walk still pending after finished translation");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= LvlFour)
    else $error("walk level out of range");

endmodule

`default_nettype wire
